// File: sv/skit_pkg.sv
// Shared constants, types and command/status structs for the sorted key index table.
`default_nettype none

package skit_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_BITS  = 16;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    // Fixed field widths of the stream words.
    localparam int OPCODE_BITS    = 2;
    localparam int KEY_FIELD_BITS = 16;
    localparam int STATUS_BITS    = 2;
    localparam int SLOT_BITS      = 4;
    localparam int TOTAL_BITS     = 5;

    localparam int S_FIELD_BITS = OPCODE_BITS + KEY_FIELD_BITS;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = STATUS_BITS + 2 * SLOT_BITS + TOTAL_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_INSERT  = 2'd0,
        OP_LOOKUP  = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_COMPACT = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Source of the shared read address of the index and keep memories.
    typedef enum logic [1:0] {
        RD_POS_M1 = 2'd0,
        RD_POS_M2 = 2'd1,
        RD_MID    = 2'd2,
        RD_IDX    = 2'd3
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        rd_sel_t rd_sel;
        logic    ins_shift;
        logic    ins_put;
        logic    srch_fetch;
        logic    srch_step;
        logic    srch_live;
        logic    keep_wr;
        logic    pass2_init;
        logic    comp_wr;
        logic    comp_done;
        logic    res_full;
        logic    res_miss;
        logic    out_load;
    } skit_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    full;
        logic    cnt_zero;
        logic    range_ok;
        logic    key_eq;
        logic    key_lt;
        logic    i_lt_cnt;
        logic    pos_one;
        logic    out_free;
    } skit_sts_t;

endpackage

`default_nettype wire

// File: sv/skit_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module skit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/skit_dpath.sv
// Datapath: index and record memories, search and walk counters, result register.
`default_nettype none

module skit_dpath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire skit_pkg::skit_cmd_t                cmd,
    output skit_pkg::skit_sts_t                     sts,
    input  wire logic [skit_pkg::S_TDATA_BITS-1:0]  s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [skit_pkg::M_TDATA_BITS-1:0]  m_tdata
);

    localparam int AB = skit_pkg::ADDR_BITS;
    localparam int CB = skit_pkg::CNT_BITS;
    localparam int KB = skit_pkg::KEY_BITS;

    skit_pkg::opcode_t op_reg;
    logic [KB-1:0]     key_reg;
    logic [CB-1:0]     count_reg;
    logic [CB-1:0]     lo_reg;
    logic [CB-1:0]     hi_reg;
    logic [CB-1:0]     pos_reg;
    logic [CB-1:0]     i_reg;
    logic [CB-1:0]     k_reg;
    logic [AB-1:0]     mid_reg;
    logic [AB-1:0]     rec_reg;
    skit_pkg::status_t res_status_reg;
    logic [AB-1:0]     res_islot_reg;
    logic [AB-1:0]     res_rslot_reg;
    logic              m_tvalid_reg;
    logic [skit_pkg::M_TDATA_BITS-1:0] m_tdata_reg;

    logic [CB:0]   mid_sum;
    logic [AB-1:0] mid;
    logic [AB-1:0] rd_addr;

    logic          key_we;
    logic [AB-1:0] key_waddr;
    logic [KB-1:0] key_wdata;
    logic [KB-1:0] rkey;
    logic          ptr_we;
    logic [AB-1:0] ptr_wdata;
    logic [AB-1:0] rptr;
    logic          live_we;
    logic [AB-1:0] live_waddr;
    logic          live_wdata;
    logic          rlive;
    logic          rkeep;

    // Lower midpoint of the half-open range [lo, hi) equals (lo + hi_inclusive) / 2.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CB{1'b0}}, 1'b1};
    assign mid     = mid_sum[AB:1];

    always_comb
    begin
        case (cmd.rd_sel)
            skit_pkg::RD_POS_M1: rd_addr = AB'(pos_reg - 1'b1);
            skit_pkg::RD_POS_M2: rd_addr = AB'(pos_reg - 2'd2);
            skit_pkg::RD_MID:    rd_addr = mid;
            skit_pkg::RD_IDX:    rd_addr = i_reg[AB-1:0];
            default:             rd_addr = i_reg[AB-1:0];
        endcase
    end

    always_comb
    begin
        key_we     = 1'b0;
        key_waddr  = pos_reg[AB-1:0];
        key_wdata  = rkey;
        ptr_we     = 1'b0;
        ptr_wdata  = rptr;
        live_we    = 1'b0;
        live_waddr = count_reg[AB-1:0];
        live_wdata = 1'b1;
        if (cmd.ins_shift)
        begin
            key_we = 1'b1;
            ptr_we = 1'b1;
        end
        if (cmd.ins_put)
        begin
            key_we    = 1'b1;
            key_wdata = key_reg;
            ptr_we    = 1'b1;
            ptr_wdata = count_reg[AB-1:0];
            live_we   = 1'b1;
        end
        if (cmd.comp_wr && rkeep)
        begin
            key_we     = 1'b1;
            key_waddr  = k_reg[AB-1:0];
            ptr_we     = 1'b1;
            ptr_wdata  = k_reg[AB-1:0];
            live_we    = 1'b1;
            live_waddr = k_reg[AB-1:0];
        end
        if (cmd.srch_live && (op_reg == skit_pkg::OP_REMOVE) && rlive)
        begin
            live_we    = 1'b1;
            live_waddr = rec_reg;
            live_wdata = 1'b0;
        end
    end

    skit_ram #(.WIDTH(KB), .DEPTH(skit_pkg::DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (rkey)
    );

    skit_ram #(.WIDTH(AB), .DEPTH(skit_pkg::DEPTH)) u_ptr_ram (
        .clk   (clk),
        .we    (ptr_we),
        .waddr (key_waddr),
        .wdata (ptr_wdata),
        .raddr (rd_addr),
        .rdata (rptr)
    );

    // The live flags are always looked up through the pointer just read.
    skit_ram #(.WIDTH(1), .DEPTH(skit_pkg::DEPTH)) u_live_ram (
        .clk   (clk),
        .we    (live_we),
        .waddr (live_waddr),
        .wdata (live_wdata),
        .raddr (rptr),
        .rdata (rlive)
    );

    // Per index position, whether compaction keeps that entry.
    skit_ram #(.WIDTH(1), .DEPTH(skit_pkg::DEPTH)) u_keep_ram (
        .clk   (clk),
        .we    (cmd.keep_wr),
        .waddr (i_reg[AB-1:0]),
        .wdata (rlive),
        .raddr (rd_addr),
        .rdata (rkeep)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ins_put)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.comp_done)
            begin
                count_reg <= k_reg;
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= skit_pkg::opcode_t'(s_tdata[skit_pkg::OPCODE_BITS-1:0]);
            key_reg <= KB'(s_tdata[skit_pkg::OPCODE_BITS +: skit_pkg::KEY_FIELD_BITS]);
            lo_reg  <= '0;
            hi_reg  <= count_reg;
            pos_reg <= count_reg;
            i_reg   <= '0;
        end
        if (cmd.ins_shift)
        begin
            pos_reg <= pos_reg - 1'b1;
        end
        if (cmd.srch_fetch)
        begin
            mid_reg <= mid;
        end
        if (cmd.srch_step)
        begin
            if (key_reg == rkey)
            begin
                rec_reg <= rptr;
            end
            else if (key_reg > rkey)
            begin
                lo_reg <= CB'(mid_reg) + 1'b1;
            end
            else
            begin
                hi_reg <= CB'(mid_reg);
            end
        end
        if (cmd.keep_wr)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.pass2_init)
        begin
            i_reg <= '0;
            k_reg <= '0;
        end
        if (cmd.comp_wr)
        begin
            i_reg <= i_reg + 1'b1;
            if (rkeep)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end

        if (cmd.ins_put)
        begin
            res_status_reg <= skit_pkg::ST_OK;
            res_islot_reg  <= pos_reg[AB-1:0];
            res_rslot_reg  <= count_reg[AB-1:0];
        end
        if (cmd.srch_live)
        begin
            res_status_reg <= rlive ? skit_pkg::ST_OK : skit_pkg::ST_MISS;
            res_islot_reg  <= rlive ? mid_reg : '0;
            res_rslot_reg  <= rlive ? rec_reg : '0;
        end
        if (cmd.res_full || cmd.res_miss || cmd.comp_done)
        begin
            res_status_reg <= cmd.res_full ? skit_pkg::ST_FULL :
                              (cmd.res_miss ? skit_pkg::ST_MISS : skit_pkg::ST_OK);
            res_islot_reg  <= '0;
            res_rslot_reg  <= '0;
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {{(skit_pkg::M_TDATA_BITS - skit_pkg::M_FIELD_BITS){1'b0}},
                            skit_pkg::TOTAL_BITS'(count_reg),
                            skit_pkg::SLOT_BITS'(res_rslot_reg),
                            skit_pkg::SLOT_BITS'(res_islot_reg),
                            res_status_reg};
        end
    end

    assign sts.op       = op_reg;
    assign sts.full     = (count_reg == CB'(skit_pkg::DEPTH));
    assign sts.cnt_zero = (count_reg == '0);
    assign sts.range_ok = (lo_reg < hi_reg);
    assign sts.key_eq   = (key_reg == rkey);
    assign sts.key_lt   = (key_reg < rkey);
    assign sts.i_lt_cnt = (i_reg < count_reg);
    assign sts.pos_one  = (pos_reg == CB'(1));
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: sv/skit_ctrl.sv
// Controller state machine that sequences insert, search and compaction steps.
`default_nettype none

module skit_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire skit_pkg::skit_sts_t sts,
    output skit_pkg::skit_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SRCH_LIVE,
        S_KP_RD,
        S_KP_PTR,
        S_KP_LIVE,
        S_KC_RD,
        S_KC_WR,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = skit_pkg::RD_IDX;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    skit_pkg::OP_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_full = 1'b1;
                            state_next   = S_FINISH;
                        end
                        else if (sts.cnt_zero)
                        begin
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            state_next = S_INS_RD;
                        end
                    end
                    skit_pkg::OP_LOOKUP,
                    skit_pkg::OP_REMOVE:  state_next = S_SRCH_RD;
                    skit_pkg::OP_COMPACT: state_next = S_KP_RD;
                    default:              state_next = S_KP_RD;
                endcase
            end
            S_INS_RD:
            begin
                cmd.rd_sel = skit_pkg::RD_POS_M1;
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                // The next lower entry is fetched while this one moves up.
                cmd.rd_sel = skit_pkg::RD_POS_M2;
                if (sts.key_lt)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = sts.pos_one ? S_INS_PUT : S_INS_CMP;
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                cmd.ins_put = 1'b1;
                state_next  = S_FINISH;
            end
            S_SRCH_RD:
            begin
                if (sts.range_ok)
                begin
                    cmd.rd_sel     = skit_pkg::RD_MID;
                    cmd.srch_fetch = 1'b1;
                    state_next     = S_SRCH_CMP;
                end
                else
                begin
                    cmd.res_miss = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_SRCH_CMP:
            begin
                cmd.srch_step = 1'b1;
                state_next    = sts.key_eq ? S_SRCH_LIVE : S_SRCH_RD;
            end
            S_SRCH_LIVE:
            begin
                cmd.srch_live = 1'b1;
                state_next    = S_FINISH;
            end
            S_KP_RD:
            begin
                if (sts.i_lt_cnt)
                begin
                    state_next = S_KP_PTR;
                end
                else
                begin
                    cmd.pass2_init = 1'b1;
                    state_next     = S_KC_RD;
                end
            end
            S_KP_PTR:
            begin
                state_next = S_KP_LIVE;
            end
            S_KP_LIVE:
            begin
                cmd.keep_wr = 1'b1;
                state_next  = S_KP_RD;
            end
            S_KC_RD:
            begin
                if (sts.i_lt_cnt)
                begin
                    state_next = S_KC_WR;
                end
                else
                begin
                    cmd.comp_done = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_KC_WR:
            begin
                cmd.comp_wr = 1'b1;
                state_next  = S_KC_RD;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// File: sv/sorted_key_index_table_core.sv
// Top level of the sorted key index table: controller plus datapath.
//
// An input word carries an opcode (insert, lookup, remove, compact) and a key.
// Each input word produces exactly one output word with status, index slot,
// record slot and the entry total after the operation.
// Words are processed one at a time; s_tready is high only while the block
// is idle. Insert moves one index entry per cycle while it shifts the
// entries above the new key's slot; lookup and remove run a binary search;
// compaction makes two passes over the single read port of the memories.
// The output word sits in a register; the next input word is accepted while
// it waits, and only the completion of that next word waits for m_tready.
// Reset empties the table (entry count zero) and drops any pending output;
// memory contents are not cleared, since only entries below the count are read.
`default_nettype none

module sorted_key_index_table_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0 up: opcode[1:0], key[17:2], zero padding.
    input  wire logic [skit_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Fields from bit 0 up: status[1:0], index_slot[5:2], record_slot[9:6],
    // entry_total[14:10], zero padding.
    output logic      [skit_pkg::M_TDATA_BITS-1:0] m_tdata
);

    skit_pkg::skit_cmd_t cmd;
    skit_pkg::skit_sts_t sts;

    skit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    skit_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// File: sim/skit_table_checker.sv
// Reply checker for the sorted key index table: predicts each reply and compares it.
`timescale 1ns / 100ps

module skit_table_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [skit_pkg::S_TDATA_BITS-1:0] s_tdata,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [skit_pkg::M_TDATA_BITS-1:0] m_tdata,
    output int                                     fail_count,
    output int                                     pending
);

    typedef struct {
        skit_pkg::status_t status;
        logic [3:0]        index_slot;
        logic [3:0]        record_slot;
        logic [4:0]        entry_total;
    } table_reply_t;

    // Shadow copy of the table.
    logic [skit_pkg::KEY_BITS-1:0] sorted_keys [skit_pkg::DEPTH];
    int                            sorted_refs [skit_pkg::DEPTH];
    logic [skit_pkg::KEY_BITS-1:0] stored_keys [skit_pkg::DEPTH];
    logic                          stored_live [skit_pkg::DEPTH];
    int                            stored_count;

    table_reply_t predicted_replies [$];
    int           mismatches = 0;
    int           waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    task automatic table_apply(input skit_pkg::opcode_t op,
                               input logic [skit_pkg::KEY_BITS-1:0] key,
                               output table_reply_t reply);
        int lo;
        int hi;
        int mid;
        int pos;
        int rec;
        int kept;
        logic [skit_pkg::KEY_BITS-1:0] kept_keys [skit_pkg::DEPTH];
        reply.status      = skit_pkg::ST_OK;
        reply.index_slot  = '0;
        reply.record_slot = '0;
        case (op)
            skit_pkg::OP_INSERT:
            begin
                if (stored_count >= skit_pkg::DEPTH)
                begin
                    reply.status = skit_pkg::ST_FULL;
                end
                else
                begin
                    rec = stored_count;
                    stored_keys[rec] = key;
                    stored_live[rec] = 1'b1;
                    // Equal keys stay ahead of the new one.
                    pos = stored_count - 1;
                    while (pos >= 0 && key < sorted_keys[pos])
                    begin
                        sorted_keys[pos + 1] = sorted_keys[pos];
                        sorted_refs[pos + 1] = sorted_refs[pos];
                        pos--;
                    end
                    sorted_keys[pos + 1] = key;
                    sorted_refs[pos + 1] = rec;
                    stored_count++;
                    reply.index_slot  = 4'(pos + 1);
                    reply.record_slot = 4'(rec);
                end
            end
            skit_pkg::OP_LOOKUP, skit_pkg::OP_REMOVE:
            begin
                reply.status = skit_pkg::ST_MISS;
                lo  = 0;
                hi  = stored_count - 1;
                pos = -1;
                while (lo <= hi && pos < 0)
                begin
                    mid = (lo + hi) / 2;
                    if (sorted_keys[mid] == key)
                        pos = mid;
                    else if (key > sorted_keys[mid])
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
                if (pos >= 0)
                begin
                    rec = sorted_refs[pos] % skit_pkg::DEPTH;
                    // Only the entry the search lands on counts, even if it is dead.
                    if (stored_keys[rec] == key && stored_live[rec])
                    begin
                        if (op == skit_pkg::OP_REMOVE)
                            stored_live[rec] = 1'b0;
                        reply.status      = skit_pkg::ST_OK;
                        reply.index_slot  = 4'(pos);
                        reply.record_slot = 4'(rec);
                    end
                end
            end
            default:
            begin
                kept = 0;
                for (int i = 0; i < stored_count; i++)
                begin
                    rec = sorted_refs[i] % skit_pkg::DEPTH;
                    if (stored_live[rec])
                    begin
                        kept_keys[kept] = stored_keys[rec];
                        kept++;
                    end
                end
                for (int i = 0; i < kept; i++)
                begin
                    stored_keys[i] = kept_keys[i];
                    stored_live[i] = 1'b1;
                    sorted_keys[i] = kept_keys[i];
                    sorted_refs[i] = i;
                end
                stored_count = kept;
            end
        endcase
        reply.entry_total = 5'(stored_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        table_reply_t reply;
        table_reply_t want;
        if (!rst_n)
        begin
            stored_count = 0;
            predicted_replies.delete();
            waiting = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                table_apply(skit_pkg::opcode_t'(s_tdata[1:0]), s_tdata[17:2], reply);
                predicted_replies.push_back(reply);
            end
            if (m_tvalid && m_tready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $error("reply word with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (m_tdata[1:0] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                        mismatches++;
                    end
                    if (m_tdata[5:2] !== want.index_slot)
                    begin
                        $error("index_slot: expected %0d, got %0d",
                               want.index_slot, m_tdata[5:2]);
                        mismatches++;
                    end
                    if (m_tdata[9:6] !== want.record_slot)
                    begin
                        $error("record_slot: expected %0d, got %0d",
                               want.record_slot, m_tdata[9:6]);
                        mismatches++;
                    end
                    if (m_tdata[14:10] !== want.entry_total)
                    begin
                        $error("entry_total: expected %0d, got %0d",
                               want.entry_total, m_tdata[14:10]);
                        mismatches++;
                    end
                end
            end
            waiting = predicted_replies.size();
        end
    end

endmodule

// File: sim/tb.sv
// Testbench top for the sorted key index table: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module tb;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [skit_pkg::S_TDATA_BITS-1:0] s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [skit_pkg::M_TDATA_BITS-1:0] m_tdata;
    int                                fail_count;
    int                                pending;

    // No idling on either side once this is set.
    logic                              quiet = 1'b0;
    int                                idle_pct = 0;
    logic [skit_pkg::KEY_BITS-1:0]     recent_keys [$];

    sorted_key_index_table_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    skit_table_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("sorted_key_index_table_core: mismatch");
        $finish;
    end

    // Reply side: ready most of the time, with stall bursts.
    initial
    begin
        @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!quiet && $urandom_range(0, 2) != 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    task automatic send_command(input skit_pkg::opcode_t op,
                                input logic [skit_pkg::KEY_BITS-1:0] key);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(skit_pkg::S_TDATA_BITS - skit_pkg::S_FIELD_BITS){1'b0}}, key, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == skit_pkg::OP_INSERT)
        begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 24)
                void'(recent_keys.pop_front());
        end
        if (!quiet && $urandom_range(1, 100) <= idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    function automatic logic [skit_pkg::KEY_BITS-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55 && recent_keys.size() > 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        else if (roll < 75)
            return skit_pkg::KEY_BITS'($urandom_range(0, 15));
        else if (roll < 80)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return skit_pkg::KEY_BITS'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        int                roll;
        int                mode;
        skit_pkg::opcode_t op;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, extreme keys, duplicates, dead entries, then fill past full.
        send_command(skit_pkg::OP_COMPACT, 16'h0000);
        send_command(skit_pkg::OP_LOOKUP, 16'h1234);
        send_command(skit_pkg::OP_REMOVE, 16'h1234);
        send_command(skit_pkg::OP_INSERT, 16'hFFFF);
        send_command(skit_pkg::OP_INSERT, 16'h0000);
        send_command(skit_pkg::OP_INSERT, 16'h8000);
        send_command(skit_pkg::OP_INSERT, 16'h8000);
        send_command(skit_pkg::OP_INSERT, 16'h7FFF);
        send_command(skit_pkg::OP_LOOKUP, 16'h0000);
        send_command(skit_pkg::OP_LOOKUP, 16'hFFFF);
        send_command(skit_pkg::OP_LOOKUP, 16'h5555);
        send_command(skit_pkg::OP_REMOVE, 16'h8000);
        send_command(skit_pkg::OP_LOOKUP, 16'h8000);
        send_command(skit_pkg::OP_REMOVE, 16'h8000);
        send_command(skit_pkg::OP_REMOVE, 16'hFFFF);
        send_command(skit_pkg::OP_LOOKUP, 16'hFFFF);
        send_command(skit_pkg::OP_COMPACT, 16'hFFFF);
        for (int i = 0; i < 15; i++)
            send_command(skit_pkg::OP_INSERT, skit_pkg::KEY_BITS'(i * 4369 + 1));
        send_command(skit_pkg::OP_COMPACT, 16'h0000);

        for (int n = 0; n < 1450; n++)
        begin
            if (n % 150 == 0)
                idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
            if (n == 1300)
                quiet = 1'b1;
            // Phases alternate between filling, churning and draining the table.
            mode = (n / 120) % 3;
            roll = $urandom_range(0, 99);
            if (mode == 0)
                op = (roll < 60) ? skit_pkg::OP_INSERT : (roll < 80) ? skit_pkg::OP_LOOKUP :
                     (roll < 96) ? skit_pkg::OP_REMOVE : skit_pkg::OP_COMPACT;
            else if (mode == 1)
                op = (roll < 30) ? skit_pkg::OP_INSERT : (roll < 60) ? skit_pkg::OP_LOOKUP :
                     (roll < 90) ? skit_pkg::OP_REMOVE : skit_pkg::OP_COMPACT;
            else
                op = (roll < 15) ? skit_pkg::OP_INSERT : (roll < 40) ? skit_pkg::OP_LOOKUP :
                     (roll < 85) ? skit_pkg::OP_REMOVE : skit_pkg::OP_COMPACT;
            send_command(op, pick_key());
        end
        s_tvalid <= 1'b0;

        // Let the checker take in the last word before its backlog is read.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("sorted_key_index_table_core: match");
        else
            $display("sorted_key_index_table_core: mismatch");
        $finish;
    end

endmodule
